// ===== sv/adsr_envelope_generator_core_assert.svh =====
// Assertion macros for the ADSR envelope generator checker.
// Used by adsr_checker.sv; no other dependencies.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH

// checked only outside reset
`define ADSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/adsr_pkg.sv =====
// Shared types and constants of the ADSR envelope generator.
// No dependencies; used by all adsr_* modules.
package adsr_pkg;

    localparam int LEVEL_W  = 25;
    localparam int ENV_W    = 26;
    localparam int NOTE_W   = 7;
    localparam int REQ_W    = 2;
    localparam int PHASE_W  = 3;
    localparam int CFG_AW   = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 56;

    localparam logic [LEVEL_W-1:0] ONE = LEVEL_W'(1) << 24;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(15099494);

    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_RELEASE = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SUSTAIN = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] release_step;
        logic [LEVEL_W-1:0] sustain_level;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        phase_t             phase;
    } stage_t;

endpackage

// ===== sv/adsr_cfg_regs.sv =====
// Configuration register file of the ADSR envelope generator.
// Depends on adsr_pkg.
module adsr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [adsr_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [adsr_pkg::LEVEL_W-1:0]  cfg_wdata,
    output adsr_pkg::cfg_t                cfg
);

    adsr_pkg::cfg_t cfg_reg;
    adsr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                adsr_pkg::CFG_ATTACK:  cfg_next.attack_step   = cfg_wdata;
                adsr_pkg::CFG_DECAY:   cfg_next.decay_step    = cfg_wdata;
                adsr_pkg::CFG_RELEASE: cfg_next.release_step  = cfg_wdata;
                adsr_pkg::CFG_SUSTAIN: cfg_next.sustain_level = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_step   <= '0;
            cfg_reg.decay_step    <= '0;
            cfg_reg.release_step  <= '0;
            cfg_reg.sustain_level <= adsr_pkg::SUSTAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/adsr_phase_ctrl.sv =====
// Envelope FSM: phase, level and last note, one sample per cycle unless stalled.
// Registers the emitted level and phase for the shaper. Depends on adsr_pkg.
module adsr_phase_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [adsr_pkg::REQ_W-1:0]    req_type,
    input  logic [adsr_pkg::NOTE_W-1:0]   note_number,
    input  adsr_pkg::cfg_t                cfg,
    output logic                          st_valid,
    input  logic                          st_ready,
    output adsr_pkg::stage_t              st_word
);

    adsr_pkg::phase_t                phase_reg, phase_next;
    logic [adsr_pkg::LEVEL_W-1:0]    level_reg, level_next;
    logic [adsr_pkg::NOTE_W-1:0]     note_reg, note_next;
    logic                            st_valid_reg, st_valid_next;
    adsr_pkg::stage_t                st_word_reg;

    logic                            accept;
    logic                            on, off_same;
    logic [adsr_pkg::LEVEL_W-1:0]    sus;
    logic                            has_decay, full, empty, below;
    logic [adsr_pkg::LEVEL_W-1:0]    lv_base, emitted;
    logic [adsr_pkg::LEVEL_W:0]      atk_sum;

    assign in_ready = !st_valid_reg || st_ready;
    assign accept   = in_valid && in_ready;

    assign on        = (req_type == adsr_pkg::REQ_NOTE_ON);
    assign off_same  = (req_type == adsr_pkg::REQ_NOTE_OFF) && (note_number == note_reg);
    assign sus       = (cfg.sustain_level > adsr_pkg::ONE) ? adsr_pkg::ONE : cfg.sustain_level;
    assign has_decay = (sus < adsr_pkg::ONE);
    assign full      = (level_reg >= adsr_pkg::ONE);
    assign empty     = (level_reg == '0);
    assign below     = (level_reg <= sus);
    assign note_next = on ? note_number : note_reg;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            adsr_pkg::PH_ATTACK: begin
                if (on)            phase_next = adsr_pkg::PH_ATTACK;
                else if (off_same) phase_next = adsr_pkg::PH_RELEASE;
                else if (full)     phase_next = has_decay ? adsr_pkg::PH_DECAY
                                                          : adsr_pkg::PH_SUSTAIN;
                else               phase_next = adsr_pkg::PH_ATTACK;
            end
            adsr_pkg::PH_DECAY: begin
                if (on)            phase_next = adsr_pkg::PH_ATTACK;
                else if (off_same) phase_next = adsr_pkg::PH_RELEASE;
                else if (below)    phase_next = adsr_pkg::PH_SUSTAIN;
                else               phase_next = adsr_pkg::PH_DECAY;
            end
            adsr_pkg::PH_SUSTAIN: begin
                if (on)            phase_next = has_decay ? adsr_pkg::PH_ATTACK
                                                          : adsr_pkg::PH_SUSTAIN;
                else if (off_same) phase_next = adsr_pkg::PH_RELEASE;
                else               phase_next = adsr_pkg::PH_SUSTAIN;
            end
            adsr_pkg::PH_RELEASE: begin
                if (on)            phase_next = adsr_pkg::PH_ATTACK;
                else if (empty)    phase_next = adsr_pkg::PH_IDLE;
                else               phase_next = adsr_pkg::PH_RELEASE;
            end
            default: begin
                phase_next = on ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_IDLE;
            end
        endcase
    end

    // emitted level and level update for the new phase
    always_comb begin
        // decay landing on sustain snaps first
        lv_base = (phase_reg == adsr_pkg::PH_DECAY && phase_next == adsr_pkg::PH_SUSTAIN)
                  ? sus : level_reg;
        atk_sum = {1'b0, lv_base} + {1'b0, cfg.attack_step};
        emitted = lv_base;
        unique case (phase_next)
            adsr_pkg::PH_ATTACK:
                level_next = (atk_sum > {1'b0, adsr_pkg::ONE}) ? adsr_pkg::ONE
                                                             : atk_sum[adsr_pkg::LEVEL_W-1:0];
            adsr_pkg::PH_DECAY:
                level_next = (lv_base < cfg.decay_step) ? '0 : lv_base - cfg.decay_step;
            adsr_pkg::PH_SUSTAIN:
                level_next = sus;
            adsr_pkg::PH_RELEASE:
                level_next = (lv_base < cfg.release_step) ? '0 : lv_base - cfg.release_step;
            default: begin
                emitted    = '0;
                level_next = '0;
            end
        endcase
    end

    assign st_valid_next = in_ready ? in_valid : st_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= adsr_pkg::PH_IDLE;
            level_reg    <= '0;
            note_reg     <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (accept) begin
                phase_reg <= phase_next;
                level_reg <= level_next;
                note_reg  <= note_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_word_reg.level <= emitted;
            st_word_reg.phase <= phase_next;
        end
    end

    assign st_valid = st_valid_reg;
    assign st_word  = st_word_reg;

endmodule

// ===== sv/adsr_shaper.sv =====
// Output stage: squares the level into 2*level^2-1 and holds the result word.
// Depends on adsr_pkg.
module adsr_shaper (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           st_valid,
    output logic                           st_ready,
    input  adsr_pkg::stage_t               st_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [adsr_pkg::M_DATA_W-1:0]  out_data
);

    localparam int PAD_W = adsr_pkg::M_DATA_W - adsr_pkg::ENV_W
                           - adsr_pkg::LEVEL_W - adsr_pkg::PHASE_W;

    logic                              out_valid_reg, out_valid_next;
    logic [adsr_pkg::M_DATA_W-1:0]     out_data_reg, out_data_next;
    logic [2*adsr_pkg::LEVEL_W-2:0]    prod;
    logic [adsr_pkg::LEVEL_W-1:0]      sq;
    logic [adsr_pkg::ENV_W-1:0]        env;

    assign st_ready = !out_valid_reg || out_ready;

    // level is at most 2^24, so the square fits in 49 bits
    assign prod = (2*adsr_pkg::LEVEL_W-1)'(st_word.level)
                * (2*adsr_pkg::LEVEL_W-1)'(st_word.level);
    assign sq   = prod[48:24];
    assign env  = {sq, 1'b0} - adsr_pkg::ENV_W'(adsr_pkg::ONE);

    assign out_data_next  = {PAD_W'(0), adsr_pkg::PHASE_W'(st_word.phase), st_word.level, env};
    assign out_valid_next = st_ready ? st_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_ready && st_valid) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/adsr_envelope_generator_core.sv =====
// ADSR envelope generator, top level.
// Depends on adsr_pkg, adsr_cfg_regs, adsr_phase_ctrl and adsr_shaper.
//
// One input word per audio sample. s_axis_tuser carries the event
// (none, note on, note off) and s_axis_tdata the note number. Each accepted
// word yields exactly one result word on m_axis: shaped envelope, linear
// level and phase.
// An accepted word passes the envelope state register, then squaring and
// the output register, to m_axis; the phase/level update is combinational.
// Throughput: one word per cycle while m_axis is not stalled.
// Configuration: cfg_we/cfg_addr/cfg_wdata write attack_step, decay_step,
// release_step and sustain_level; write only while no word is in flight.
// Reset (aresetn low, synchronous): steps to zero, sustain to its default,
// phase idle, level zero, last note zero, both stages empty.
// Stall: when m_axis_tready is low the result holds; the state stage
// takes one more word, then s_axis_tready drops until the output drains.
module adsr_envelope_generator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [6:0] note_number, [7] zero
    input  logic [adsr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [adsr_pkg::REQ_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [25:0] envelope_out, [50:26] level_out, [53:51] phase_out, [55:54] zero
    output logic [adsr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [adsr_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [adsr_pkg::LEVEL_W-1:0]   cfg_wdata
);

    adsr_pkg::cfg_t    cfg;
    adsr_pkg::stage_t  st_word;
    logic              st_valid;
    logic              st_ready;

    adsr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    adsr_phase_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .req_type    (s_axis_tuser),
        .note_number (s_axis_tdata[adsr_pkg::NOTE_W-1:0]),
        .cfg         (cfg),
        .st_valid    (st_valid),
        .st_ready    (st_ready),
        .st_word     (st_word)
    );

    adsr_shaper u_shaper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st_valid  (st_valid),
        .st_ready  (st_ready),
        .st_word   (st_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== sv/adsr_checker.sv =====
// Port-level checks of the ADSR envelope generator, bound to the top level.
// Depends on adsr_pkg and adsr_envelope_generator_core_assert.svh.
`include "adsr_envelope_generator_core_assert.svh"

module adsr_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [adsr_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    logic [adsr_pkg::ENV_W-1:0]    env_f;
    logic [adsr_pkg::LEVEL_W-1:0]  lvl_f;
    logic [adsr_pkg::PHASE_W-1:0]  ph_f;

    assign env_f = m_axis_tdata[25:0];
    assign lvl_f = m_axis_tdata[50:26];
    assign ph_f  = m_axis_tdata[53:51];

    `ADSR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_axis_tvalid,
        "output valid after reset")

    `ADSR_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    `ADSR_ASSERT(a_ready_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready,
        "input stalled while output free")

    `ADSR_ASSERT(a_level_range, m_axis_tvalid |-> lvl_f <= adsr_pkg::ONE,
        "level above full scale")

    `ADSR_ASSERT(a_idle_floor, m_axis_tvalid && ph_f == adsr_pkg::PH_IDLE |->
        lvl_f == '0 && env_f == (adsr_pkg::ENV_W'(0) - adsr_pkg::ENV_W'(adsr_pkg::ONE)),
        "idle word not at floor")

endmodule

bind adsr_envelope_generator_core adsr_checker u_adsr_checker (.*);
